FILE: hw/rtl/alist_pkg.sv
// Package: sizes, codes and cell control type for the array list unit.
package alist_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  // Length runs 0..CAPACITY; cell indexes and positions share this width.
  localparam int LEN_W    = (POS_W > $clog2(CAPACITY + 1)) ? POS_W : $clog2(CAPACITY + 1);
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // Broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic             ins;   // open a slot at pidx and load the new value
    logic             del;   // close the slot at pidx
    logic [LEN_W-1:0] pidx;  // zero-based target index
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/alist_if.sv
// Request and response channel interfaces of the array list unit.
interface alist_req_if;
  import alist_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  modport source(output valid, opcode, position, value, input ready);
  modport sink(input valid, opcode, position, value, output ready);
endinterface

interface alist_rsp_if;
  import alist_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data_out;
  logic [POS_W-1:0]         count;
  modport source(output valid, status, data_out, count, input ready);
  modport sink(input valid, status, data_out, count, output ready);
endinterface

FILE: hw/rtl/alist_cell.sv
// One list slot: holds an entry and shifts with its neighbors.
module alist_cell (
  input  logic                          clk,
  input  logic [alist_pkg::LEN_W-1:0]   idx,
  input  alist_pkg::cell_ctrl_t         ctrl,
  input  logic [alist_pkg::DATA_W-1:0]  new_val,
  input  logic [alist_pkg::DATA_W-1:0]  left,
  input  logic [alist_pkg::DATA_W-1:0]  right,
  output logic [alist_pkg::DATA_W-1:0]  entry,
  output logic [alist_pkg::DATA_W-1:0]  rd
);
  import alist_pkg::*;

  logic at_pos;
  logic past_pos;

  assign at_pos   = (idx == ctrl.pidx);
  assign past_pos = (idx >= ctrl.pidx);

  // Only the addressed slot drives its value toward the gather tree.
  assign rd = at_pos ? entry : '0;

  // Insert: load at target, take lower neighbor above it. Delete: take upper neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (at_pos) begin
        entry <= new_val;
      end else if (past_pos) begin
        entry <= left;
      end
    end else if (ctrl.del && past_pos) begin
      entry <= right;
    end
  end

endmodule

FILE: hw/rtl/alist_gather.sv
// Registered OR tree that collects the addressed slot's value.
module alist_gather (
  input  logic                          clk,
  input  logic                          capture,
  input  logic [alist_pkg::DATA_W-1:0]  cell_rd [alist_pkg::CAPACITY],
  output logic [alist_pkg::DATA_W-1:0]  data
);
  import alist_pkg::*;

  logic [DATA_W-1:0] grp_next [NGROUP];
  logic [DATA_W-1:0] grp      [NGROUP];

  // First level: OR within each group of cells.
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | cell_rd[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      grp <= grp_next;
    end
  end

  // Second level: OR across the registered groups.
  always_comb begin
    data = '0;
    for (int g = 0; g < NGROUP; g++) begin
      data = data | grp[g];
    end
  end

endmodule

FILE: hw/rtl/array_list_insert_delete_unit.sv
// Top level: ordered list of signed words kept in a chain of shifting cells.
//
//  Channel | Direction | Payload
//  --------+-----------+-------------------------------------
//  req     | in        | opcode, position, value
//  rsp     | out       | status, data_out, count
//
// Every item gives one response: the accept edge shifts the cells and registers
// the group ORs, and the response register loads when the item leaves the
// pending stage. One item per cycle is taken while responses drain; the
// two-level OR gather registers its groups ahead of the response. Reset empties
// the list at once (no sweep); a stalled response holds and at most one more
// item waits behind it.
module array_list_insert_delete_unit (
  input logic        clk,
  input logic        rst,
  alist_req_if.sink  req,
  alist_rsp_if.source rsp
);
  import alist_pkg::*;

  logic [LEN_W-1:0]  list_length;
  logic [LEN_W-1:0]  list_length_next;
  logic              accept;
  logic              advance;
  logic              pend;
  stat_t             pend_stat;
  logic              pend_rd_ok;
  logic [LEN_W-1:0]  pend_count;
  stat_t             stat_next;
  logic              rd_ok_next;
  logic [LEN_W:0]    pos_ext;
  logic [LEN_W:0]    len_ext;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_entry [CAPACITY];
  logic [DATA_W-1:0] cell_rd    [CAPACITY];
  logic [DATA_W-1:0] gathered;

  assign advance   = pend && (!rsp.valid || rsp.ready);
  assign req.ready = !pend || advance;
  assign accept    = req.valid && req.ready;

  assign pos_ext = (LEN_W + 1)'(req.position);
  assign len_ext = (LEN_W + 1)'(list_length);

  // Decode the request against the current length.
  always_comb begin
    stat_next        = ST_OK;
    rd_ok_next       = 1'b0;
    list_length_next = list_length;
    ctrl.ins         = 1'b0;
    ctrl.del         = 1'b0;
    ctrl.pidx        = LEN_W'(req.position) - LEN_W'(1);
    case (op_t'(req.opcode))
      OP_INSERT: begin
        if (pos_ext == '0 || pos_ext > len_ext + (LEN_W + 1)'(1)) begin
          stat_next = ST_RANGE;
        end else if (len_ext >= (LEN_W + 1)'(CAPACITY)) begin
          stat_next = ST_FULL;
        end else begin
          ctrl.ins         = accept;
          list_length_next = list_length + LEN_W'(1);
        end
      end
      OP_DELETE, OP_READ: begin
        if (pos_ext == '0 || pos_ext > len_ext) begin
          stat_next = ST_RANGE;
        end else begin
          rd_ok_next = 1'b1;
          if (op_t'(req.opcode) == OP_DELETE) begin
            ctrl.del         = accept;
            list_length_next = list_length - LEN_W'(1);
          end
        end
      end
      default: begin
        stat_next = ST_OK;
      end
    endcase
  end

  // Chain of cells; the ends see zero beyond the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_entry[i+1];
    end
    alist_cell u_cell (
      .clk     (clk),
      .idx     (LEN_W'(i)),
      .ctrl    (ctrl),
      .new_val (req.value),
      .left    (left_val),
      .right   (right_val),
      .entry   (cell_entry[i]),
      .rd      (cell_rd[i])
    );
  end

  alist_gather u_gather (
    .clk     (clk),
    .capture (accept),
    .cell_rd (cell_rd),
    .data    (gathered)
  );

  // Length and pending stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= '0;
      pend        <= 1'b0;
    end else begin
      if (accept) begin
        list_length <= list_length_next;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (advance) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_stat  <= stat_next;
      pend_rd_ok <= rd_ok_next;
      pend_count <= list_length_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status   <= pend_stat;
      rsp.data_out <= pend_rd_ok ? gathered : '0;
      rsp.count    <= POS_W'(pend_count);
    end
  end

  // Checks
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    list_length <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_len_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> list_length == $past(list_length))
    else $error("length changed without an item");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> rsp.count == POS_W'(CAPACITY))
    else $error("full status with list not at capacity");

  a_range_data: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> rsp.data_out == '0)
    else $error("rejected item returned data");

endmodule
